FILE: rtl/eegbd_pkg.sv
`timescale 1ns / 1ps

package eegbd_pkg;

  // Samples per averaging window. The average is taken with a shift, so this
  // stays a power of two.
  localparam int unsigned WINDOW_SAMPLES = 64;
  localparam int unsigned WIN_SHIFT      = $clog2(WINDOW_SAMPLES);

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned AVG_W    = 13;
  localparam int unsigned MAG_W    = 13;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Largest folded magnitude is 4096.
  localparam int unsigned MAG_MAX   = 4096;
  localparam int unsigned WIN_CNT_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned WIN_SUM_W = $clog2(WINDOW_SAMPLES * MAG_MAX + 1);

  // Calibration runs over three window averages.
  localparam int unsigned CALIB_WINDOWS = 3;
  localparam int unsigned CALIB_CNT_W   = 2;
  localparam int unsigned CALIB_SUM_W   = $clog2(CALIB_WINDOWS * MAG_MAX + 1);
  localparam int unsigned ARM3_W        = LIMIT_W + 2;

  // Packet framing bytes.
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'd170;
  localparam logic [BYTE_W-1:0] SMALL_LEN = 8'd4;
  localparam logic [BYTE_W-1:0] BIG_LEN   = 8'd32;

  localparam logic [IDX_W-1:0] SMALL_HI_IDX   = IDX_W'(2);
  localparam logic [IDX_W-1:0] SMALL_LAST_IDX = IDX_W'(3);
  localparam logic [IDX_W-1:0] BIG_QUAL_IDX   = IDX_W'(1);
  localparam logic [IDX_W-1:0] BIG_LAST_IDX   = IDX_W'(31);

  // Register reset values.
  localparam logic [LIMIT_W-1:0] BLINK_LOW_RST  = LIMIT_W'(110);
  localparam logic [LIMIT_W-1:0] BLINK_HIGH_RST = LIMIT_W'(350);
  localparam logic [LIMIT_W-1:0] ARM_LIMIT_RST  = LIMIT_W'(70);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK_LOW  = 2'd0,
    CFG_BLINK_HIGH = 2'd1,
    CFG_ARM_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_OFF   = 2'd1,
    LED_FIRST = 2'd2,
    LED_ALL   = 2'd3
  } led_mode_e;

  typedef enum logic [5:0] {
    PH_SYNC1 = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_SMALL = 6'b001000,
    PH_CHECK = 6'b010000,
    PH_BIG   = 6'b100000
  } phase_e;

  // A small packet whose check byte just arrived, with its folded sample.
  typedef struct packed {
    logic             sample_ok;
    logic [MAG_W-1:0] mag;
  } pkt_evt_t;

  typedef struct packed {
    logic             beep;
    led_mode_e        led_mode;
    logic [AVG_W-1:0] avg;
  } win_res_t;

  // Fold a 16-bit raw sample to a magnitude: negative codes are negated.
  function automatic logic [MAG_W-1:0] fold_sample(input logic [15:0] raw);
    logic [MAG_W-1:0] lo12;
    lo12 = {1'b0, raw[11:0]};
    if (raw[15:12] != 4'd0) begin
      fold_sample = {1'b0, ~raw[11:0]} + MAG_W'(1);
    end else begin
      fold_sample = lo12;
    end
  endfunction

endpackage

FILE: rtl/eeg_packet_blink_detector.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o    | rx_byte_i
// out      | output    | out_valid_o / out_stall_i  | beep_o, led_mode_o, window_average_o
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One byte is taken per clock cycle while the input does not stall. An accepted byte is
// held in the input register, is parsed and scored there, and a closing window loads its
// result into the output register when that byte moves on from the input register.
// Reset (rst_ni low, asynchronous) returns the parser to hunting the first sync byte,
// empties the window and calibration and loads the limit registers with their defaults.
// The input stalls only when the byte in the input register closes a window while the
// output register still holds a result that the sink is stalling; any other byte moves on.
// Configuration writes are always ready and take effect on the next cycle.
module eeg_packet_blink_detector import eegbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 beep_o,
  output logic [1:0]           led_mode_o,
  output logic [AVG_W-1:0]     window_average_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LIMIT_W-1:0]   cfg_data_i
);

  logic               in_valid_q;
  logic [BYTE_W-1:0]  in_byte_q;
  logic               out_valid_q;
  logic               beep_q;
  logic [1:0]         led_q;
  logic [AVG_W-1:0]   avg_q;
  logic [LIMIT_W-1:0] blink_low_q, blink_high_q, arm_limit_q;

  logic      fire;
  logic      emit;
  logic      out_blocked;
  logic      quality_ok;
  pkt_evt_t  evt;
  win_res_t  res;

  // The output register is only busy for a byte that actually closes a window.
  assign out_blocked = out_valid_q && out_stall_i;
  assign fire        = in_valid_q && !(emit && out_blocked);
  assign in_stall_o  = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Limit registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_low_q  <= BLINK_LOW_RST;
      blink_high_q <= BLINK_HIGH_RST;
      arm_limit_q  <= ARM_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BLINK_LOW:  blink_low_q  <= cfg_data_i;
        CFG_BLINK_HIGH: blink_high_q <= cfg_data_i;
        CFG_ARM_LIMIT:  arm_limit_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  eegbd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (in_byte_q),
    .evt_o        (evt),
    .quality_ok_o (quality_ok)
  );

  eegbd_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .evt_i        (evt),
    .quality_ok_i (quality_ok),
    .blink_low_i  (blink_low_q),
    .blink_high_i (blink_high_q),
    .arm_limit_i  (arm_limit_q),
    .emit_o       (emit),
    .res_o        (res)
  );

  // Output register: loaded when a window closes, emptied when the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      beep_q <= res.beep;
      led_q  <= res.led_mode;
      avg_q  <= res.avg;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign beep_o           = beep_q;
  assign led_mode_o       = led_q;
  assign window_average_o = avg_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(avg_q) && $stable(led_q)))
    else $error("pending result overwritten");

  a_stall_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && emit && out_blocked))
    else $error("input stalled without a blocked window close");

endmodule

FILE: rtl/eegbd_parser.sv
`timescale 1ns / 1ps

module eegbd_parser import eegbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] byte_i,
  output pkt_evt_t          evt_o,
  output logic              quality_ok_o
);

  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [BYTE_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0]  hi_q, hi_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               qual_q, qual_d;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    hi_d    = hi_q;
    mag_d   = mag_q;
    qual_d  = qual_q;
    evt_o.sample_ok = 1'b0;
    evt_o.mag       = mag_q;
    unique case (phase_q)
      PH_SYNC2: begin
        phase_d = (byte_i == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
      end
      PH_LEN: begin
        idx_d = '0;
        sum_d = '0;
        if (byte_i == SMALL_LEN) begin
          phase_d = PH_SMALL;
        end else if (byte_i == BIG_LEN) begin
          phase_d = PH_BIG;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_SMALL: begin
        sum_d = sum_q + byte_i;
        if (idx_q == SMALL_HI_IDX) begin
          hi_d = byte_i;
        end
        if (idx_q >= SMALL_LAST_IDX) begin
          // The low byte completes the sample; fold it now so the folded
          // sample is ready in mag_q when the check byte arrives.
          mag_d   = fold_sample({hi_q, byte_i});
          phase_d = PH_CHECK;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      PH_CHECK: begin
        phase_d = PH_SYNC1;
        evt_o.sample_ok = (byte_i == ~sum_q);
      end
      PH_BIG: begin
        if (idx_q == BIG_QUAL_IDX) begin
          hi_d = byte_i;
        end
        if (idx_q >= BIG_LAST_IDX) begin
          qual_d  = (hi_q == '0);
          phase_d = PH_SYNC1;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: begin
        phase_d = (byte_i == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      idx_q   <= '0;
      sum_q   <= '0;
      hi_q    <= '0;
      qual_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      hi_q    <= hi_d;
      qual_q  <= qual_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      mag_q <= mag_d;
    end
  end

  assign quality_ok_o = qual_q;

  a_small_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SMALL) |-> (idx_q <= SMALL_LAST_IDX))
    else $error("small packet byte index out of range");

  a_check_from_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PH_SMALL && idx_q == SMALL_LAST_IDX) |=> (phase_q == PH_CHECK))
    else $error("last small payload byte did not lead to the check byte");

endmodule

FILE: rtl/eegbd_window.sv
`timescale 1ns / 1ps

module eegbd_window import eegbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  pkt_evt_t           evt_i,
  input  logic               quality_ok_i,
  input  logic [LIMIT_W-1:0] blink_low_i,
  input  logic [LIMIT_W-1:0] blink_high_i,
  input  logic [LIMIT_W-1:0] arm_limit_i,
  output logic               emit_o,
  output win_res_t           res_o
);

  logic [WIN_CNT_W-1:0]   count_q, count_d;
  logic [WIN_SUM_W-1:0]   sum_q, sum_d;
  logic [CALIB_CNT_W-1:0] ccnt_q, ccnt_d;
  logic [CALIB_SUM_W-1:0] csum_q, csum_d;
  logic                   armed_q, armed_d;
  logic                   armed_mid;
  logic                   window_open;
  logic [AVG_W-1:0]       avg;
  logic [ARM3_W-1:0]      arm3;

  assign window_open = (count_q < WIN_CNT_W'(WINDOW_SAMPLES));
  assign emit_o      = evt_i.sample_ok && !window_open;
  assign avg         = AVG_W'(sum_q >> WIN_SHIFT);
  // floor(sum / 3) < limit is the same as sum < 3 * limit.
  assign arm3        = (ARM3_W'(arm_limit_i) << 1) + ARM3_W'(arm_limit_i);

  always_comb begin
    count_d   = count_q;
    sum_d     = sum_q;
    ccnt_d    = ccnt_q;
    csum_d    = csum_q;
    armed_mid = armed_q;
    armed_d   = armed_q;
    res_o.beep     = 1'b0;
    res_o.led_mode = LED_KEEP;
    res_o.avg      = avg;

    if (!armed_q) begin
      if (ccnt_q < CALIB_CNT_W'(CALIB_WINDOWS)) begin
        csum_d = csum_q + CALIB_SUM_W'(avg);
        ccnt_d = ccnt_q + CALIB_CNT_W'(1);
      end else begin
        armed_mid = (ARM3_W'(csum_q) < arm3);
        ccnt_d    = '0;
        csum_d    = '0;
      end
    end
    armed_d = armed_mid;

    if (!quality_ok_i) begin
      res_o.led_mode = LED_FIRST;
    end else if (!armed_mid) begin
      res_o.led_mode = LED_OFF;
    end else if (avg > blink_low_i && avg < blink_high_i) begin
      res_o.beep = 1'b1;
    end else if (avg > blink_high_i) begin
      res_o.led_mode = LED_ALL;
      armed_d        = 1'b0;
    end

    if (window_open) begin
      sum_d   = sum_q + WIN_SUM_W'(evt_i.mag);
      count_d = count_q + WIN_CNT_W'(1);
    end else begin
      sum_d   = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ccnt_q  <= '0;
      csum_q  <= '0;
      armed_q <= 1'b0;
    end else if (fire_i && evt_i.sample_ok) begin
      count_q <= count_d;
      sum_q   <= sum_d;
      if (!window_open) begin
        ccnt_q  <= ccnt_d;
        csum_q  <= csum_d;
        armed_q <= armed_d;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WIN_CNT_W'(WINDOW_SAMPLES))
    else $error("window count above window size");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && emit_o) |=> (count_q == '0 && sum_q == '0))
    else $error("closed window not cleared");

  a_off_head_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && emit_o && res_o.led_mode == LED_ALL) |=> !armed_q)
    else $error("over-range average did not disarm");

endmodule

FILE: sim/eeg_packet_blink_detector_tb.sv
`timescale 1ns / 1ps

// The bench streams serial bytes into the packet parser and predicts, byte by byte, when a
// window of small packets closes and what the closed window reports. Directed tests come
// first and walk through the framing corner cases, the arming calibration, every branch of
// the blink decision and the limit extremes. A long random test follows.
module eeg_packet_blink_detector_tb;
  import eegbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // Clock, reset and the ports of the block. Every input has a known value from time zero.
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 beep;
  logic [1:0]           led_mode;
  logic [AVG_W-1:0]     window_average;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  eeg_packet_blink_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .beep_o           (beep),
    .led_mode_o       (led_mode),
    .window_average_o (window_average),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bookkeeping shared by the stimulus and the result checker.
  win_res_t    pending_windows[$];
  int unsigned windows_closed = 0;
  int unsigned windows_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  // Private copy of the parser, the window and the calibration, kept in step with every
  // byte transfer that the block accepts.
  phase_e             rx_phase = PH_SYNC1;
  logic [IDX_W-1:0]   rx_pos = '0;
  logic [BYTE_W-1:0]  hold_hi = '0;
  logic [BYTE_W-1:0]  hold_lo = '0;
  logic [BYTE_W-1:0]  pay_sum = '0;
  bit                 signal_good = 1'b0;
  bit                 detect_armed = 1'b0;
  int unsigned        win_fill = 0;
  int unsigned        win_total = 0;
  int unsigned        cal_windows = 0;
  int unsigned        cal_total = 0;
  logic [LIMIT_W-1:0] lim_low = BLINK_LOW_RST;
  logic [LIMIT_W-1:0] lim_high = BLINK_HIGH_RST;
  logic [LIMIT_W-1:0] lim_arm = ARM_LIMIT_RST;

  // A raw sample with any of its top four bits set is a negative code, and its magnitude is
  // the two's complement of the low twelve bits.
  function automatic int unsigned magnitude_of(input logic [15:0] raw);
    if (raw[15:12] != 4'h0) begin
      return int'(raw[11:0] ^ 12'hFFF) + 1;
    end
    return int'(raw[11:0]);
  endfunction

  // Scores the window that the current packet closes and queues the result that it yields.
  // Calibration runs before the decision, so the window that arms the block is scored as
  // armed.
  task automatic close_window();
    int unsigned avg;
    win_res_t    res;
    avg = win_total / WINDOW_SAMPLES;
    if (!detect_armed) begin
      if (cal_windows < CALIB_WINDOWS) begin
        cal_total += avg;
        cal_windows++;
      end else begin
        if (cal_total / CALIB_WINDOWS < int'(lim_arm)) detect_armed = 1'b1;
        cal_windows = 0;
        cal_total = 0;
      end
    end
    res.beep = 1'b0;
    res.led_mode = LED_KEEP;
    res.avg = AVG_W'(avg);
    if (!signal_good) begin
      res.led_mode = LED_FIRST;
    end else if (!detect_armed) begin
      res.led_mode = LED_OFF;
    end else if (avg > int'(lim_low) && avg < int'(lim_high)) begin
      res.beep = 1'b1;
    end else if (avg > int'(lim_high)) begin
      // A window above the blink band means the sensor left the head.
      res.led_mode = LED_ALL;
      detect_armed = 1'b0;
    end
    win_fill = 0;
    win_total = 0;
    windows_closed++;
    pending_windows.push_back(res);
  endtask

  // Advances the predicted parser by one accepted byte.
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    case (rx_phase)
      PH_SYNC2: begin
        rx_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
      end
      PH_LEN: begin
        rx_pos = '0;
        pay_sum = '0;
        if (b == SMALL_LEN) rx_phase = PH_SMALL;
        else if (b == BIG_LEN) rx_phase = PH_BIG;
        else rx_phase = PH_SYNC1;
      end
      PH_SMALL: begin
        pay_sum = pay_sum + b;
        if (rx_pos == SMALL_HI_IDX) hold_hi = b;
        if (rx_pos >= SMALL_LAST_IDX) begin
          hold_lo = b;
          rx_phase = PH_CHECK;
          rx_pos = '0;
        end else begin
          rx_pos = rx_pos + 1'b1;
        end
      end
      PH_CHECK: begin
        rx_phase = PH_SYNC1;
        // A packet with a bad check byte is dropped without a trace.
        if (b == ~pay_sum) begin
          if (win_fill < WINDOW_SAMPLES) begin
            win_total += magnitude_of({hold_hi, hold_lo});
            win_fill++;
          end else begin
            // The packet that closes a full window loses its own sample.
            close_window();
          end
        end
      end
      PH_BIG: begin
        if (rx_pos == BIG_QUAL_IDX) hold_hi = b;
        if (rx_pos >= BIG_LAST_IDX) begin
          signal_good = (hold_hi == 8'h00);
          rx_phase = PH_SYNC1;
          rx_pos = '0;
        end else begin
          rx_pos = rx_pos + 1'b1;
        end
      end
      default: begin
        rx_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: window %0d: %s is %0d, expected %0d", windows_checked, what, got, want);
    error_count++;
  endtask

  // Sends one byte. It is entered at a falling edge and returns at the falling edge after
  // the transfer, with valid still high so that a following byte goes out without a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk_i); while (in_stall);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted result has arrived, then lets the pipeline
  // run empty, since the last bytes in flight may cause no result at all.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Configuration writes happen only while the block is idle.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_BLINK_LOW:  lim_low = value;
      CFG_BLINK_HIGH: lim_high = value;
      CFG_ARM_LIMIT:  lim_arm = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Builds a raw sample of the given magnitude, as a positive or a negative code.
  function automatic logic [15:0] raw_for_mag(input int unsigned mag);
    logic [15:0] raw;
    if (mag == 0 || (mag < MAG_MAX && $urandom_range(0, 1) == 0)) begin
      raw = {4'h0, 12'(mag)};
    end else begin
      raw[11:0] = 12'(mag - 1) ^ 12'hFFF;
      raw[15:12] = 4'($urandom_range(1, 15));
    end
    return raw;
  endfunction

  task automatic send_small(input logic [15:0] raw, input bit good);
    logic [BYTE_W-1:0] p0, p1, sum, chk;
    p0 = 8'($urandom);
    p1 = 8'($urandom);
    sum = p0 + p1 + raw[15:8] + raw[7:0];
    chk = ~sum;
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(SMALL_LEN);
    send_byte(p0);
    send_byte(p1);
    send_byte(raw[15:8]);
    send_byte(raw[7:0]);
    send_byte(chk);
  endtask

  task automatic send_big(input logic [BYTE_W-1:0] quality);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(BIG_LEN);
    for (int i = 0; i <= int'(BIG_LAST_IDX); i++) begin
      send_byte((i == int'(BIG_QUAL_IDX)) ? quality : 8'($urandom));
    end
  endtask

  // Sends good small packets with magnitudes in [lo, hi] until a window closes. With lo
  // equal to hi and a fresh window, the average comes out exactly at that magnitude.
  task automatic fill_window(input int unsigned lo, input int unsigned hi);
    int unsigned start;
    start = windows_closed;
    do send_small(raw_for_mag($urandom_range(lo, hi)), 1'b1);
    while (windows_closed == start);
  endtask

  task automatic arm_detector(input int unsigned hi);
    for (int k = 0; k < 8 && !detect_armed; k++) fill_window(0, hi);
  endtask

  // Framing corner cases, then sample extremes, closed out under poor signal quality.
  task automatic test_framing_cases();
    send_byte(SYNC_BYTE);
    send_byte(8'h55);           // A wrong second sync byte restarts the hunt.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h07);           // So does a length that is neither small nor big.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);       // A sync byte in the length slot is a bad length too.
    send_big(8'h5A);            // Big packets have no check byte, so the next sync is
    send_small(16'h0000, 1'b1); // parsed straight away.
    send_small(16'h0FFF, 1'b1);
    send_small(16'h1000, 1'b1);
    send_small(16'hF000, 1'b1);
    send_small(16'hFFFF, 1'b1);
    send_small(16'h8000, 1'b1);
    send_small(16'h7FFF, 1'b1);
    send_small(16'h0123, 1'b0); // A bad check byte drops the packet.
    fill_window(0, MAG_MAX);
  endtask

  // With the reset limits, arm the detector and visit every branch of the decision,
  // including averages that sit exactly on each limit.
  task automatic test_blink_decisions();
    send_big(8'h00);
    arm_detector(40);
    fill_window(200, 200);
    fill_window(110, 110);
    fill_window(111, 111);
    fill_window(349, 349);
    fill_window(350, 350);
    fill_window(351, 351);      // Disarms.
    fill_window(200, 200);      // Unarmed with good quality.
    send_big(8'h01);
    fill_window(200, 200);      // Poor quality again.
    send_big(8'h00);
  endtask

  task automatic test_limit_extremes();
    write_limit(CFG_BLINK_LOW, '0);
    write_limit(CFG_BLINK_HIGH, LIMIT_W'(MAG_MAX));
    write_limit(CFG_ARM_LIMIT, LIMIT_W'(MAG_MAX));
    arm_detector(100);
    fill_window(MAG_MAX, MAG_MAX);
    fill_window(1, 1);
    fill_window(0, 0);
    // Values beyond the sample range are compared as written.
    write_limit(CFG_BLINK_HIGH, '1);
    write_limit(CFG_BLINK_LOW, '1);
    write_limit(CFG_ARM_LIMIT, '0);
    fill_window(MAG_MAX, MAG_MAX);
    write_limit(CFG_BLINK_HIGH, '0);
    fill_window(1, 1);          // Anything above a zero high limit disarms.
    repeat (4) fill_window(0, 10);
    write_limit(CFG_BLINK_HIGH, '0 - 1'b1 - 1'b1); // Index 3 below leaves all limits alone.
    write_limit(2'd3, LIMIT_W'($urandom));
    write_limit(CFG_BLINK_LOW, BLINK_LOW_RST);
    write_limit(CFG_BLINK_HIGH, BLINK_HIGH_RST);
    write_limit(CFG_ARM_LIMIT, ARM_LIMIT_RST);
    fill_window(0, 400);
  endtask

  // The sender waits for the closing result before it goes on.
  task automatic test_pressure();
    fill_window(0, 600);
    wait_drained();
    repeat (10) send_small(raw_for_mag($urandom_range(0, 600)), 1'b1);
    wait_drained();
    fill_window(0, 600);
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    repeat (3) fill_window(0, 500);
    gaps_on = 1'b1;
  endtask

  // Mostly runs of good packets at a chosen level, mixed with quality packets, noise,
  // broken packets and limit changes.
  task automatic test_random_traffic();
    int unsigned items_goal, windows_goal, pick, lo, hi;
    logic [BYTE_W-1:0] b;
    items_goal = bytes_sent + 1800;
    windows_goal = windows_closed + 40;
    while (bytes_sent < items_goal || windows_closed < windows_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 3))
          0: begin lo = $urandom_range(0, 60); hi = lo + $urandom_range(0, 20); end
          1: begin lo = $urandom_range(100, 360); hi = lo + $urandom_range(0, 10); end
          2: begin lo = $urandom_range(300, MAG_MAX); hi = lo; end
          default: begin lo = 0; hi = MAG_MAX; end
        endcase
        if (hi > MAG_MAX) hi = MAG_MAX;
        repeat ($urandom_range(20, 70)) send_small(raw_for_mag($urandom_range(lo, hi)), 1'b1);
      end else if (pick < 80) begin
        send_big(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: send_byte(SYNC_BYTE);
            1: send_byte(SMALL_LEN);
            2: send_byte(BIG_LEN);
            default: send_byte(8'($urandom));
          endcase
        end
      end else if (pick < 96) begin
        case ($urandom_range(0, 3))
          0: send_small(16'($urandom), 1'b0);
          1: begin
            send_byte(SYNC_BYTE);
            send_byte(SYNC_BYTE);
            send_byte(SMALL_LEN);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
          end
          2: begin
            do b = 8'($urandom); while (b == SMALL_LEN || b == BIG_LEN);
            send_byte(SYNC_BYTE);
            send_byte(SYNC_BYTE);
            send_byte(b);
          end
          default: begin
            do b = 8'($urandom); while (b == SYNC_BYTE);
            send_byte(SYNC_BYTE);
            send_byte(b);
          end
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0: b = 8'h00;
          default: b = 8'hFF;
        endcase
        case ($urandom_range(0, 4))
          0: write_limit(CFG_IDX_W'($urandom_range(0, 3)), '0);
          1: write_limit(CFG_IDX_W'($urandom_range(0, 3)), LIMIT_W'(MAG_MAX));
          2: write_limit(CFG_IDX_W'($urandom_range(0, 3)), '1);
          3: write_limit(CFG_IDX_W'($urandom_range(0, 3)), LIMIT_W'($urandom));
          default: write_limit(CFG_IDX_W'($urandom_range(0, 3)), LIMIT_W'($urandom_range(0, 500)));
        endcase
      end
    end
  endtask

  // The sink stalls at random, except in stretches with gaps switched off.
  always @(negedge clk_i) begin
    out_stall = gaps_on && ($urandom_range(0, 99) < 16);
  end

  // Every result transfer is compared, field by field, with the oldest predicted window.
  always @(posedge clk_i) begin : check_results
    win_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        report_mismatch("result transfer with nothing pending", 1, 0);
      end else begin
        want = pending_windows.pop_front();
        if (beep !== want.beep) report_mismatch("beep", beep, want.beep);
        if (led_mode !== want.led_mode) report_mismatch("led_mode", led_mode, want.led_mode);
        if (window_average !== want.avg) begin
          report_mismatch("window_average", window_average, want.avg);
        end
      end
      windows_checked++;
    end
  end

  // A hung block or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("eeg_packet_blink_detector_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_framing_cases();
    test_blink_decisions();
    test_limit_extremes();
    test_pressure();
    test_no_gaps();
    test_random_traffic();
    // Drain every predicted window, then give the pipeline time to show anything extra.
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && pending_windows.size() == 0) begin
      $display("eeg_packet_blink_detector_tb OK");
    end else begin
      $display("eeg_packet_blink_detector_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/eegbd_pkg.sv
rtl/eegbd_parser.sv
rtl/eegbd_window.sv
rtl/eeg_packet_blink_detector.sv
sim/eeg_packet_blink_detector_tb.sv
